### hw/rtl/gtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_pkg: shared constants and helpers
// Fixed-point constants, register indexes and the CORDIC arctangent table
// for the go-to-goal proportional controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int CORDIC_STEPS = 16;      // 8 .. 32
    localparam int CORDIC_W     = 36;      // x/y datapath of the CORDIC
    localparam int ANGLE_W      = 21;      // CORDIC angle accumulator
    localparam int REG_W        = 20;
    localparam int CFG_IDX_W    = 3;
    localparam int DIST_W       = 31;

    localparam logic signed [ANGLE_W-1:0] FX_PI     = 21'sd205887;
    localparam logic signed [ANGLE_W-1:0] FX_TWO_PI = 21'sd411775;
    localparam logic [DIST_W-1:0]         DIST_MAX  = 31'h7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_RADIUS = 3'd4;

    localparam logic [REG_W-1:0] RST_LINEAR_GAIN    = 20'd13107;
    localparam logic [REG_W-1:0] RST_ANGULAR_GAIN   = 20'd17039;
    localparam logic [REG_W-1:0] RST_LINEAR_LIMIT   = 20'd45875;
    localparam logic [REG_W-1:0] RST_ANGULAR_LIMIT  = 20'd39322;
    localparam logic [REG_W-1:0] RST_ARRIVAL_RADIUS = 20'd3277;

    // atan(2^-i) in Q16.16 radians
    function automatic logic [16:0] atan_val(input int i);
        logic [16:0] v;
        case (i)
            0:       v = 17'd51472;
            1:       v = 17'd30386;
            2:       v = 17'd16055;
            3:       v = 17'd8150;
            4:       v = 17'd4091;
            5:       v = 17'd2047;
            6:       v = 17'd1024;
            7:       v = 17'd512;
            8:       v = 17'd256;
            9:       v = 17'd128;
            10:      v = 17'd64;
            11:      v = 17'd32;
            12:      v = 17'd16;
            13:      v = 17'd8;
            14:      v = 17'd4;
            15:      v = 17'd2;
            16:      v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/gtg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_if: channel interfaces
// Pose input, command output and register write channels.
// ----------------------------------------------------------------------------
interface gtg_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [18:0]  heading;
    logic signed [31:0]  goal_x;
    logic signed [31:0]  goal_y;
    modport source (output valid, pos_x, pos_y, heading, goal_x, goal_y, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, goal_x, goal_y, output ready);
endinterface

interface gtg_out_if;
    logic                valid;
    logic                ready;
    logic [19:0]         linear_cmd;
    logic signed [20:0]  angular_cmd;
    logic                arrived;
    modport source (output valid, linear_cmd, angular_cmd, arrived, input ready);
    modport sink   (input valid, linear_cmd, angular_cmd, arrived, output ready);
endinterface

interface gtg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [19:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/go_to_goal_p_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_core: go-to-goal proportional controller
// Distance and bearing to the goal, proportional linear and angular
// commands with limits, arrival detection.
//
//   channel | dir | beat
//   i_in    | in  | pos_x, pos_y, heading, goal_x, goal_y
//   o_out   | out | linear_cmd, angular_cmd, arrived
//   i_cfg   | in  | index, data (register write)
//
// One pose per cycle while the output is not stalled; the pipeline is the
// 32-stage square root plus offset, magnitude, square, sum and command stages.
// Synchronous reset clears valid bits and restores the register defaults.
// A stalled output freezes the whole pipeline; the input is ready whenever
// the output register is empty or being read.
// ----------------------------------------------------------------------------
module go_to_goal_p_controller_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gtg_in_if.sink        i_in,
    gtg_out_if.source     o_out,
    gtg_cfg_if.sink       i_cfg
);
    localparam int LAT   = 40;
    localparam int SIDE  = 34;                          // stage 2 -> stage 36
    localparam int ZDLY  = SIDE - gtg_pkg::CORDIC_STEPS;
    localparam int RW    = gtg_pkg::REG_W;
    localparam int AW    = gtg_pkg::ANGLE_W;
    localparam int CW    = gtg_pkg::CORDIC_W;
    localparam int DW    = gtg_pkg::DIST_W;

    // configuration
    logic [RW-1:0] r_linear_gain, r_angular_gain, r_linear_limit;
    logic [RW-1:0] r_angular_limit, r_arrival_radius;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear_gain    <= gtg_pkg::RST_LINEAR_GAIN;
            r_angular_gain   <= gtg_pkg::RST_ANGULAR_GAIN;
            r_linear_limit   <= gtg_pkg::RST_LINEAR_LIMIT;
            r_angular_limit  <= gtg_pkg::RST_ANGULAR_LIMIT;
            r_arrival_radius <= gtg_pkg::RST_ARRIVAL_RADIUS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                gtg_pkg::REG_LINEAR_GAIN:    r_linear_gain    <= i_cfg.data;
                gtg_pkg::REG_ANGULAR_GAIN:   r_angular_gain   <= i_cfg.data;
                gtg_pkg::REG_LINEAR_LIMIT:   r_linear_limit   <= i_cfg.data;
                gtg_pkg::REG_ANGULAR_LIMIT:  r_angular_limit  <= i_cfg.data;
                gtg_pkg::REG_ARRIVAL_RADIUS: r_arrival_radius <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic           en;
    logic [LAT-1:0] r_v;

    assign en         = !r_v[LAT-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAT-2:0], i_in.valid};
        end
    end

    // stage 1: offset to goal
    logic signed [32:0] r1_dx, r1_dy;
    logic signed [18:0] r1_hd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= 33'(i_in.goal_x) - 33'(i_in.pos_x);
            r1_dy <= 33'(i_in.goal_y) - 33'(i_in.pos_y);
            r1_hd <= i_in.heading;
        end
    end

    // stage 2: magnitudes, saturation, CORDIC pre-rotation
    logic [32:0]            ax, ay;
    logic signed [CW-1:0]   dx_w, dy_w;
    logic [DW-1:0]          r2_ax, r2_ay;
    logic                   r2_sat;
    logic signed [18:0]     r2_hd;
    logic signed [CW-1:0]   r2_cx, r2_cy;
    logic signed [AW-1:0]   r2_cz;

    always_comb begin
        ax   = r1_dx[32] ? 33'(-r1_dx) : 33'(r1_dx);
        ay   = r1_dy[32] ? 33'(-r1_dy) : 33'(r1_dy);
        dx_w = CW'(r1_dx);
        dy_w = CW'(r1_dy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ax  <= ax[DW-1:0];
            r2_ay  <= ay[DW-1:0];
            r2_sat <= (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
            r2_hd  <= r1_hd;
            if (r1_dx[32]) begin
                r2_cx <= -dx_w;
                r2_cy <= -dy_w;
                r2_cz <= r1_dy[32] ? -gtg_pkg::FX_PI : gtg_pkg::FX_PI;
            end else begin
                r2_cx <= dx_w;
                r2_cy <= dy_w;
                r2_cz <= '0;
            end
        end
    end

    // stages 3 and 4: squares and their sum
    logic [61:0] r3_sqx, r3_sqy;
    logic [62:0] r4_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sqx <= r2_ax * r2_ax;
            r3_sqy <= r2_ay * r2_ay;
            r4_sum <= 63'(r3_sqx) + 63'(r3_sqy);
        end
    end

    // stages 5 to 36: square root
    logic [31:0] root;

    gtg_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r4_sum),
        .o_root (root)
    );

    // bearing, then aligned to the root
    logic signed [AW-1:0] cz;
    logic signed [AW-1:0] r_zd [ZDLY];

    gtg_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r2_cx),
        .i_y   (r2_cy),
        .i_z   (r2_cz),
        .o_z   (cz)
    );

    logic signed [18:0] r_hd_d  [SIDE];
    logic [SIDE-1:0]    r_sat_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zd[0]   <= cz;
            r_hd_d[0] <= r2_hd;
            r_sat_d   <= {r_sat_d[SIDE-2:0], r2_sat};
            for (int i = 1; i < ZDLY; i++) begin
                r_zd[i] <= r_zd[i-1];
            end
            for (int i = 1; i < SIDE; i++) begin
                r_hd_d[i] <= r_hd_d[i-1];
            end
        end
    end

    // stage 37: distance, raw heading error
    logic [DW-1:0]        r37_dist;
    logic signed [AW:0]   r37_w;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r37_dist <= (r_sat_d[SIDE-1] || root[31]) ? gtg_pkg::DIST_MAX : root[DW-1:0];
            r37_w    <= (AW+1)'(r_zd[ZDLY-1]) - (AW+1)'(r_hd_d[SIDE-1]);
        end
    end

    // stage 38: arrival, linear product, wrap
    logic                 r38_arr;
    logic [DW+RW-1:0]     r38_lprod;
    logic signed [AW-1:0] r38_w;
    logic signed [AW:0]   pi_w, two_pi_w;

    assign pi_w     = (AW+1)'(gtg_pkg::FX_PI);
    assign two_pi_w = (AW+1)'(gtg_pkg::FX_TWO_PI);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r38_arr   <= r37_dist <= DW'(r_arrival_radius);
            r38_lprod <= r37_dist * r_linear_gain;
            if (r37_w > pi_w) begin
                r38_w <= AW'(r37_w - two_pi_w);
            end else if (r37_w < -pi_w) begin
                r38_w <= AW'(r37_w + two_pi_w);
            end else begin
                r38_w <= AW'(r37_w);
            end
        end
    end

    // stage 39: linear cap, angular product
    logic [DW+RW-17:0]         lsh;
    logic                      r39_arr;
    logic [RW-1:0]             r39_lin;
    logic signed [AW+RW:0]     r39_aprod;

    assign lsh = r38_lprod[DW+RW-1:16];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r39_arr   <= r38_arr;
            r39_lin   <= (lsh > (DW+RW-16)'(r_linear_limit)) ? r_linear_limit : lsh[RW-1:0];
            r39_aprod <= $signed({1'b0, r_angular_gain}) * r38_w;
        end
    end

    // stage 40: angular clamp, output register
    logic signed [AW+RW-16:0] ash, alim;
    logic [RW-1:0]            r_out_lin;
    logic signed [20:0]       r_out_ang;
    logic                     r_out_arr;

    assign ash  = r39_aprod[AW+RW:16];
    assign alim = (AW+RW-15)'(r_angular_limit);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_arr <= r39_arr;
            if (r39_arr) begin
                r_out_lin <= '0;
                r_out_ang <= '0;
            end else begin
                r_out_lin <= r39_lin;
                if (ash > alim) begin
                    r_out_ang <= 21'(alim);
                end else if (ash < -alim) begin
                    r_out_ang <= 21'(-alim);
                end else begin
                    r_out_ang <= 21'(ash);
                end
            end
        end
    end

    assign o_out.valid       = r_v[LAT-1];
    assign o_out.linear_cmd  = r_out_lin;
    assign o_out.angular_cmd = r_out_ang;
    assign o_out.arrived     = r_out_arr;

    // checks
    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.arrived |-> o_out.linear_cmd == '0 && o_out.angular_cmd == '0)
        else $error("arrived beat with non-zero command");

    a_lin_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.linear_cmd <= r_linear_limit)
        else $error("linear command above limit");

    a_ang_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> 22'(o_out.angular_cmd) <= 22'($signed({2'b00, r_angular_limit}))
                     && 22'(o_out.angular_cmd) >= -22'($signed({2'b00, r_angular_limit})))
        else $error("angular command outside limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_v == $past(r_v))
        else $error("valid bits moved during stall");

endmodule

### hw/rtl/gtg_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_isqrt: pipelined integer square root
// Restoring square root of a 63-bit value, one result bit per stage,
// 32 stages, floor result.
// ----------------------------------------------------------------------------
module gtg_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [62:0] i_rad,
    output logic [31:0] o_root
);
    localparam int STAGES = 32;

    logic [63:0] r_rem  [STAGES];
    logic [63:0] r_root [STAGES];

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
            logic [63:0] rem_in, root_in, trial, n_rem, n_root;
            if (k == 0) begin : g_first
                assign rem_in  = {1'b0, i_rad};
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
            end
            always_comb begin
                trial = root_in + BIT;
                if (rem_in >= trial) begin
                    n_rem  = rem_in - trial;
                    n_root = (root_in >> 1) + BIT;
                end else begin
                    n_rem  = rem_in;
                    n_root = root_in >> 1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                end
            end
        end
    endgenerate

    assign o_root = r_root[STAGES-1][31:0];

endmodule

### hw/rtl/gtg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_cordic: pipelined vectoring CORDIC
// Drives y towards zero, one micro-rotation per stage, and accumulates
// the bearing in Q16.16 radians.
// ----------------------------------------------------------------------------
module gtg_cordic (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [gtg_pkg::CORDIC_W-1:0]    i_x,
    input  logic signed [gtg_pkg::CORDIC_W-1:0]    i_y,
    input  logic signed [gtg_pkg::ANGLE_W-1:0]     i_z,
    output logic signed [gtg_pkg::ANGLE_W-1:0]     o_z
);
    localparam int S = gtg_pkg::CORDIC_STEPS;

    logic signed [gtg_pkg::CORDIC_W-1:0] r_x [S];
    logic signed [gtg_pkg::CORDIC_W-1:0] r_y [S];
    logic signed [gtg_pkg::ANGLE_W-1:0]  r_z [S];

    genvar k;
    generate
        for (k = 0; k < S; k++) begin : g_stage
            localparam logic signed [gtg_pkg::ANGLE_W-1:0] ATAN =
                gtg_pkg::ANGLE_W'(gtg_pkg::atan_val(k));
            logic signed [gtg_pkg::CORDIC_W-1:0] x_in, y_in, n_x, n_y;
            logic signed [gtg_pkg::ANGLE_W-1:0]  z_in, n_z;
            if (k == 0) begin : g_first
                assign x_in = i_x;
                assign y_in = i_y;
                assign z_in = i_z;
            end else begin : g_next
                assign x_in = r_x[k-1];
                assign y_in = r_y[k-1];
                assign z_in = r_z[k-1];
            end
            always_comb begin
                if (!y_in[gtg_pkg::CORDIC_W-1] && (y_in != '0)) begin
                    n_x = x_in + (y_in >>> k);
                    n_y = y_in - (x_in >>> k);
                    n_z = z_in + ATAN;
                end else begin
                    n_x = x_in - (y_in >>> k);
                    n_y = y_in + (x_in >>> k);
                    n_z = z_in - ATAN;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k] <= n_x;
                    r_y[k] <= n_y;
                    r_z[k] <= n_z;
                end
            end
        end
    endgenerate

    assign o_z = r_z[S-1];

endmodule

### verif/go_to_goal_p_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_core_tb: self-checking bench for the controller
// Poses and goals go in through the pose channel and gains, limits and the
// arrival radius through the register channel. An in-bench model of the
// distance, CORDIC bearing and command logic predicts every command beat,
// and the monitor compares each one against the oldest prediction.
// ----------------------------------------------------------------------------
module go_to_goal_p_controller_core_tb;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [18:0] heading;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
    } pose_t;

    typedef struct packed {
        logic [19:0]        linear_cmd;
        logic signed [20:0] angular_cmd;
        logic               arrived;
    } cmd_t;

    localparam int  LATENCY   = 40;
    localparam int  MAX_CYCLE = 400000;
    localparam int  N_RANDOM  = 1725;
    localparam longint D_MAX  = 64'sd2147483647;

    logic i_clk;
    logic i_rst_n;

    gtg_in_if  pose_ch ();
    gtg_out_if cmd_ch ();
    gtg_cfg_if cfg_ch ();

    go_to_goal_p_controller_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pose_ch.sink),
        .o_out   (cmd_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    logic [19:0] lin_gain, ang_gain, lin_lim, ang_lim, arr_rad;

    pose_t  pose_q[$];
    cmd_t   cmd_expected_q[$];
    int     errors;
    int     cmds_seen;
    int     arrivals_seen;
    longint cycle;
    bit     no_idle;
    bit     hold_poses;
    int     send_gap;
    int     stall_len;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle = 0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle > MAX_CYCLE) begin
                $display("timeout at %0t", $time);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(input longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic longint goal_bearing(input longint dx, input longint dy);
        longint x, y, z, nx;
        longint atan_k[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2, 1};
        x = dx;
        y = dy;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = (dy >= 0) ? longint'(gtg_pkg::FX_PI) : -longint'(gtg_pkg::FX_PI);
        end
        for (int i = 0; i < gtg_pkg::CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + shr_floor(y, i);
                y  = y - shr_floor(x, i);
                z += (i < 17) ? atan_k[i] : 0;
            end else begin
                nx = x - shr_floor(y, i);
                y  = y + shr_floor(x, i);
                z -= (i < 17) ? atan_k[i] : 0;
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic cmd_t steer_command(input pose_t p);
        cmd_t   c;
        longint dx, dy, ax, ay, span, lin, w, ang, lim;
        dx = longint'(p.goal_x) - longint'(p.pos_x);
        dy = longint'(p.goal_y) - longint'(p.pos_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax > D_MAX || ay > D_MAX) span = D_MAX;
        else begin
            span = isqrt(longint'(ax * ax) + longint'(ay * ay));
            if (span > D_MAX) span = D_MAX;
        end
        c = '0;
        if (span <= longint'(arr_rad)) begin
            c.arrived = 1'b1;
            return c;
        end
        lin = shr_floor(longint'(lin_gain) * span, 16);
        if (lin > longint'(lin_lim)) lin = longint'(lin_lim);
        w = goal_bearing(dx, dy) - longint'(p.heading);
        while (w > longint'(gtg_pkg::FX_PI)) w -= longint'(gtg_pkg::FX_TWO_PI);
        while (w < -longint'(gtg_pkg::FX_PI)) w += longint'(gtg_pkg::FX_TWO_PI);
        ang = shr_floor(longint'(ang_gain) * w, 16);
        lim = longint'(ang_lim);
        if (ang > lim) ang = lim;
        if (ang < -lim) ang = -lim;
        c.linear_cmd  = lin[19:0];
        c.angular_cmd = ang[20:0];
        return c;
    endfunction

    // pose driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pose_ch.valid <= 1'b0;
            send_gap      <= 0;
        end else if (pose_ch.valid && !pose_ch.ready) begin
            // hold the beat
        end else if (send_gap > 0) begin
            pose_ch.valid <= 1'b0;
            send_gap      <= send_gap - 1;
        end else if (pose_q.size() > 0 && !hold_poses) begin
            pose_t p;
            p = pose_q.pop_front();
            pose_ch.valid   <= 1'b1;
            pose_ch.pos_x   <= p.pos_x;
            pose_ch.pos_y   <= p.pos_y;
            pose_ch.heading <= p.heading;
            pose_ch.goal_x  <= p.goal_x;
            pose_ch.goal_y  <= p.goal_y;
            if (!no_idle && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 8);
        end else begin
            pose_ch.valid <= 1'b0;
        end
    end

    // result stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.ready <= 1'b0;
            stall_len    <= 0;
        end else if (stall_len > 0) begin
            cmd_ch.ready <= 1'b0;
            stall_len    <= stall_len - 1;
        end else if (!no_idle && $urandom_range(0, 15) == 0) begin
            cmd_ch.ready <= 1'b0;
            stall_len    <= $urandom_range(0, 7);
        end else begin
            cmd_ch.ready <= 1'b1;
        end
    end

    // pose acceptance feeds the prediction; command beats are checked
    always @(posedge i_clk) begin
        if (i_rst_n && pose_ch.valid && pose_ch.ready) begin
            pose_t p;
            p.pos_x   = pose_ch.pos_x;
            p.pos_y   = pose_ch.pos_y;
            p.heading = pose_ch.heading;
            p.goal_x  = pose_ch.goal_x;
            p.goal_y  = pose_ch.goal_y;
            cmd_expected_q.push_back(steer_command(p));
        end
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                gtg_pkg::REG_LINEAR_GAIN:    lin_gain = cfg_ch.data;
                gtg_pkg::REG_ANGULAR_GAIN:   ang_gain = cfg_ch.data;
                gtg_pkg::REG_LINEAR_LIMIT:   lin_lim  = cfg_ch.data;
                gtg_pkg::REG_ANGULAR_LIMIT:  ang_lim  = cfg_ch.data;
                gtg_pkg::REG_ARRIVAL_RADIUS: arr_rad  = cfg_ch.data;
                default: ;
            endcase
        end
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            cmd_t got, want;
            got.linear_cmd  = cmd_ch.linear_cmd;
            got.angular_cmd = cmd_ch.angular_cmd;
            got.arrived     = cmd_ch.arrived;
            cmds_seen++;
            if (got.arrived) arrivals_seen++;
            if (cmd_expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat %h", $time, got);
            end else begin
                want = cmd_expected_q.pop_front();
                if (got.linear_cmd !== want.linear_cmd) begin
                    errors++;
                    $display("%0t: linear_cmd exp %0d got %0d", $time,
                             want.linear_cmd, got.linear_cmd);
                end
                if (got.angular_cmd !== want.angular_cmd) begin
                    errors++;
                    $display("%0t: angular_cmd exp %0d got %0d", $time,
                             want.angular_cmd, got.angular_cmd);
                end
                if (got.arrived !== want.arrived) begin
                    errors++;
                    $display("%0t: arrived exp %0b got %0b", $time,
                             want.arrived, got.arrived);
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain;
        while (pose_q.size() > 0 || pose_ch.valid || cmd_expected_q.size() > 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0:       return $signed($urandom());
            1:       return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic pose_t rand_pose(input int r);
        pose_t p;
        int    m;
        m = $urandom_range(0, 3);
        p.pos_x   = rand_coord(m);
        p.pos_y   = rand_coord(m);
        p.heading = $urandom_range(0, 3) == 0 ? 19'($urandom()) :
                    19'($signed($urandom_range(0, 411774)) - 205887);
        case ($urandom_range(0, 5))
            0: begin // close to the goal, around the arrival radius
                p.goal_x = p.pos_x + $signed($urandom_range(0, 2 * r + 2)) - r - 1;
                p.goal_y = p.pos_y + $signed($urandom_range(0, 2 * r + 2)) - r - 1;
            end
            1: begin
                p.goal_x = p.pos_x + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                p.goal_y = p.pos_y + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            end
            default: begin
                p.goal_x = rand_coord(m);
                p.goal_y = rand_coord(m);
            end
        endcase
        return p;
    endfunction

    function automatic pose_t mk(input logic signed [31:0] px, py, input logic signed [18:0] h,
                                 input logic signed [31:0] gx, gy);
        pose_t p;
        p.pos_x = px; p.pos_y = py; p.heading = h; p.goal_x = gx; p.goal_y = gy;
        return p;
    endfunction

    initial begin
        errors = 0; cmds_seen = 0; arrivals_seen = 0;
        no_idle = 1'b0; hold_poses = 1'b0;
        lin_gain = gtg_pkg::RST_LINEAR_GAIN;  ang_gain = gtg_pkg::RST_ANGULAR_GAIN;
        lin_lim  = gtg_pkg::RST_LINEAR_LIMIT; ang_lim  = gtg_pkg::RST_ANGULAR_LIMIT;
        arr_rad  = gtg_pkg::RST_ARRIVAL_RADIUS;
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        pose_ch.valid = 1'b0; pose_ch.pos_x = '0; pose_ch.pos_y = '0;
        pose_ch.heading = '0; pose_ch.goal_x = '0; pose_ch.goal_y = '0;
        cmd_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset register values
        pose_q.push_back(mk(0, 0, 0, 0, 0));                     // goal on position
        pose_q.push_back(mk(0, 0, 0, 3277, 0));                  // right at the radius
        pose_q.push_back(mk(0, 0, 0, 3278, 0));
        pose_q.push_back(mk(0, 0, 205887, -65536, 0));           // behind, heading at pi
        pose_q.push_back(mk(0, 0, -205887, -65536, 0));
        pose_q.push_back(mk(0, 0, 0, -65536, -1));
        pose_q.push_back(mk(0, 0, 19'sh3FFFF, 0, 65536));        // heading bits at extremes
        pose_q.push_back(mk(0, 0, 19'sh40000, 0, -65536));
        pose_q.push_back(mk(0, 0, -1, 65536, 65536));
        pose_q.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 0,
                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF));    // saturated distance
        pose_q.push_back(mk(32'sh7FFF_FFFF, 0, 100000, 32'sh8000_0000, 0));
        pose_q.push_back(mk(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        pose_q.push_back(mk(-1, -1, 0, 32'sh7FFF_FFFF, 32'sh8000_0000));
        pose_q.push_back(mk(0, 0, 0, 0, -65536));
        pose_q.push_back(mk(0, 0, 0, 100, 0));
        drain();
        repeat (LATENCY) @(posedge i_clk);

        // register extremes
        write_reg(gtg_pkg::REG_LINEAR_GAIN, 20'hFFFFF);
        write_reg(gtg_pkg::REG_ANGULAR_GAIN, 20'hFFFFF);
        write_reg(gtg_pkg::REG_LINEAR_LIMIT, 20'hFFFFF);
        write_reg(gtg_pkg::REG_ANGULAR_LIMIT, 20'hFFFFF);
        write_reg(gtg_pkg::REG_ARRIVAL_RADIUS, 20'd0);
        write_reg(3'd7, 20'h12345);                              // index out of range
        pose_q.push_back(mk(0, 0, 0, 0, 0));
        pose_q.push_back(mk(0, 0, 0, 1, 0));
        pose_q.push_back(mk(0, 0, 205887, -1, 0));
        pose_q.push_back(mk(0, 0, -205887, 32'sh7FFF_FFFF, 1));
        pose_q.push_back(mk(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        pose_q.push_back(mk(5, 5, 0, 5, 6));
        drain();
        repeat (LATENCY) @(posedge i_clk);

        // random phases, each with its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 6) begin
                hold_poses = 1'b1;   // let everything drain with the sender held
                drain();
                hold_poses = 1'b0;
            end
            if (ph == 7) no_idle = 1'b1;
            write_reg(gtg_pkg::REG_LINEAR_GAIN, ph == 1 ? 20'd0 : 20'($urandom()));
            write_reg(gtg_pkg::REG_ANGULAR_GAIN, ph == 1 ? 20'd0 : 20'($urandom()));
            write_reg(gtg_pkg::REG_LINEAR_LIMIT,
                      ph == 2 ? 20'd655360 : 20'($urandom_range(0, 655360)));
            write_reg(gtg_pkg::REG_ANGULAR_LIMIT,
                      ph == 2 ? 20'd0 : 20'($urandom_range(0, 655360)));
            write_reg(gtg_pkg::REG_ARRIVAL_RADIUS,
                      ph == 3 ? 20'd655360 : 20'($urandom_range(0, 65536)));
            for (int k = 0; k < N_RANDOM / 8; k++) pose_q.push_back(rand_pose(int'(arr_rad)));
            drain();
            repeat (LATENCY) @(posedge i_clk);
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        $display("%0d command beats checked, %0d of them arrivals, over 10 register settings",
                 cmds_seen, arrivals_seen);
        $display("directed extremes, saturated distance, wrap at +/-pi and random poses");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
